### sv/qtla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtla_pkg: shared types and constants for the Q-table agent
// Payload structs, command codes, sequencer states and saturation helper.
// ----------------------------------------------------------------------------
package qtla_pkg;

   localparam int STATE_COUNT  = 1024;
   localparam int ACTION_COUNT = 8;
   localparam int STATE_W      = $clog2(STATE_COUNT);
   localparam int ACT_W        = $clog2(ACTION_COUNT);
   localparam int ADDR_W       = STATE_W + ACT_W;
   localparam int DEPTH        = STATE_COUNT * ACTION_COUNT;

   localparam logic [1:0] CSR_ALPHA    = 2'd0;
   localparam logic [1:0] CSR_DISCOUNT = 2'd1;
   localparam logic [1:0] CSR_EXPLOIT  = 2'd2;

   localparam logic [16:0] ALPHA_RST    = 17'd6554;
   localparam logic [16:0] DISCOUNT_RST = 17'd65536;
   localparam logic [15:0] EXPLOIT_RST  = 16'd58982;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_READ   = 2'd1,
      CMD_SELECT = 2'd2,
      CMD_UPDATE = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [9:0]         state;
      logic [2:0]         action;
      logic [9:0]         dest_state;
      logic signed [31:0] reward;
      logic signed [31:0] write_value;
      logic [7:0]         valid_mask;
      logic [15:0]        explore_draw;
      logic [2:0]         random_pick;
   } req_type;

   typedef struct packed {
      logic [2:0]         chosen_action;
      logic               explored;
      logic               pick_rejected;
      logic               no_valid_action;
      logic signed [31:0] q_value;
      logic signed [31:0] delta;
   } rsp_type;

   // front to back handoff
   typedef struct packed {
      logic    vld;
      cmd_type kind;
   } fq_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_READ_DATA,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_TD,
      ST_MUL2,
      ST_STEP,
      ST_WB
   } bstate_type;

   typedef struct packed {
      logic [16:0] alpha;
      logic [16:0] discount;
      logic [15:0] exploit_thresh;
   } cfg_type;

   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      logic signed [31:0] r;
      if (v > 37'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -37'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### sv/qtla_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtla_front: request intake
// Two-entry word queue; classifies each command for the back end.
// ----------------------------------------------------------------------------
module qtla_front import qtla_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_item,
   output fq_type  fq_info,
   output req_type fq_item,
   input  logic    fq_take
);

   req_type    mem_ff [2];
   cmd_type    kind_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;
   cmd_type    kind_in;

   assign req_full = (cnt_ff == 2'd2);
   assign do_push  = req_push && !req_full;
   assign do_pop   = fq_take && (cnt_ff != 2'd0);

   always_comb begin
      case (req_item.command)
         CMD_WRITE:  kind_in = CMD_WRITE;
         CMD_READ:   kind_in = CMD_READ;
         CMD_SELECT: kind_in = CMD_SELECT;
         default:    kind_in = CMD_UPDATE;
      endcase
   end

   always_comb begin
      wptr_in = do_push ? ~wptr_ff : wptr_ff;
      rptr_in = do_pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff]  <= req_item;
         kind_ff[wptr_ff] <= kind_in;
      end
   end

   assign fq_info.vld  = (cnt_ff != 2'd0);
   assign fq_info.kind = kind_ff[rptr_ff];
   assign fq_item      = mem_ff[rptr_ff];

endmodule

### sv/qtla_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtla_back: table sequencer
// Holds the action-value RAM, scans rows for the greedy action and runs the
// two-multiply update with saturation; one word at a time.
// ----------------------------------------------------------------------------
module qtla_back import qtla_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  fq_type  fq_info,
   input  req_type fq_item,
   output logic    fq_take,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_item
);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rd_ff;

   bstate_type         st_ff, st_in;
   req_type            item_ff;
   cmd_type            kind_ff;
   logic [ACT_W-1:0]   cnt_ff;
   logic               cmp_vld_ff;
   logic [ACT_W-1:0]   cmp_idx_ff;
   logic               found_ff;
   logic signed [31:0] best_ff;
   logic [ACT_W-1:0]   arg_ff;
   logic signed [31:0] cur_ff;
   logic signed [49:0] prod1_ff;
   logic signed [34:0] td_ff;
   logic signed [52:0] prod2_ff;
   logic signed [31:0] step_ff;
   logic               out_vld_ff;
   rsp_type            out_ff;

   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic               wr_en;
   logic signed [31:0] wr_data;
   logic               load_out;
   rsp_type            out_in;

   logic [STATE_W-1:0] scan_row;
   logic signed [49:0] prod1_rnd;
   logic signed [33:0] scaled;
   logic signed [52:0] prod2_rnd;
   logic signed [32:0] nq_sum;
   logic signed [31:0] nq;
   logic               pick_ok;

   assign scan_row = (kind_ff == CMD_UPDATE) ? item_ff.dest_state[STATE_W-1:0]
                                             : item_ff.state[STATE_W-1:0];
   assign wr_addr  = {item_ff.state[STATE_W-1:0], item_ff.action[ACT_W-1:0]};

   assign prod1_rnd = prod1_ff + 50'sd32768;
   assign scaled    = prod1_rnd[49:16];
   assign prod2_rnd = prod2_ff + 53'sd32768;
   assign nq_sum    = {cur_ff[31], cur_ff} + {step_ff[31], step_ff};
   assign nq        = sat32({{4{nq_sum[32]}}, nq_sum});
   assign pick_ok   = item_ff.valid_mask[item_ff.random_pick];

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (fq_info.vld && !out_vld_ff) begin
               case (fq_info.kind)
                  CMD_WRITE: st_in = ST_WRITE;
                  CMD_READ:  st_in = ST_READ;
                  default:   st_in = ST_SCAN;
               endcase
            end
         end
         ST_WRITE:     st_in = ST_IDLE;
         ST_READ:      st_in = ST_READ_DATA;
         ST_READ_DATA: st_in = ST_IDLE;
         ST_SCAN: begin
            if (cnt_ff == ACT_W'(ACTION_COUNT - 1)) begin
               st_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END:  st_in = ST_DECIDE;
         ST_DECIDE: begin
            st_in = (kind_ff == CMD_UPDATE && found_ff) ? ST_TD : ST_IDLE;
         end
         ST_TD:        st_in = ST_MUL2;
         ST_MUL2:      st_in = ST_STEP;
         ST_STEP:      st_in = ST_WB;
         ST_WB:        st_in = ST_IDLE;
         default:      st_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      fq_take  = 1'b0;
      rd_addr  = wr_addr;
      wr_en    = 1'b0;
      wr_data  = item_ff.write_value;
      load_out = 1'b0;
      out_in   = '0;
      case (st_ff)
         ST_IDLE: begin
            fq_take = fq_info.vld && !out_vld_ff;
         end
         ST_WRITE: begin
            wr_en          = 1'b1;
            load_out       = 1'b1;
            out_in.q_value = item_ff.write_value;
         end
         ST_READ_DATA: begin
            load_out       = 1'b1;
            out_in.q_value = rd_ff;
         end
         ST_SCAN: begin
            rd_addr = {scan_row, cnt_ff};
         end
         ST_DECIDE: begin
            if (!found_ff) begin
               load_out               = 1'b1;
               out_in.no_valid_action = 1'b1;
               if (kind_ff == CMD_UPDATE) begin
                  out_in.q_value = rd_ff;
               end
            end else if (kind_ff == CMD_SELECT) begin
               load_out = 1'b1;
               if (item_ff.explore_draw <= cfg.exploit_thresh) begin
                  out_in.chosen_action = 3'(arg_ff);
               end else begin
                  out_in.explored      = 1'b1;
                  out_in.chosen_action = item_ff.random_pick;
                  out_in.pick_rejected = !pick_ok;
               end
            end
         end
         ST_WB: begin
            wr_en                = 1'b1;
            wr_data              = nq;
            load_out             = 1'b1;
            out_in.chosen_action = 3'(arg_ff);
            out_in.q_value       = nq;
            out_in.delta         = step_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         out_vld_ff <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         cmp_vld_ff <= (st_ff == ST_SCAN);
         if (load_out) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fq_take) begin
         item_ff  <= fq_item;
         kind_ff  <= fq_info.kind;
         cnt_ff   <= '0;
         found_ff <= 1'b0;
      end else if (st_ff == ST_SCAN) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      cmp_idx_ff <= cnt_ff;
      // running lowest-index maximum; strict compare keeps the first one
      if (cmp_vld_ff && item_ff.valid_mask[cmp_idx_ff] &&
          (!found_ff || rd_ff > best_ff)) begin
         found_ff <= 1'b1;
         best_ff  <= rd_ff;
         arg_ff   <= cmp_idx_ff;
      end
      if (st_ff == ST_DECIDE) begin
         cur_ff   <= rd_ff;
         prod1_ff <= $signed({1'b0, cfg.discount}) * best_ff;
      end
      if (st_ff == ST_TD) begin
         td_ff <= {{3{item_ff.reward[31]}}, item_ff.reward} +
                  {scaled[33], scaled} - {{3{cur_ff[31]}}, cur_ff};
      end
      if (st_ff == ST_MUL2) begin
         prod2_ff <= $signed({1'b0, cfg.alpha}) * td_ff;
      end
      if (st_ff == ST_STEP) begin
         step_ff <= sat32(prod2_rnd[52:16]);
      end
      if (load_out) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty = !out_vld_ff;
   assign rsp_item  = out_ff;

endmodule

### sv/q_table_learning_agent_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q_table_learning_agent_core: tabular Q-learning agent
// One word in flight in the sequencer; the row scan reads one RAM entry
// per cycle. Reset clears control and restores the registers; table
// contents undefined.
// ----------------------------------------------------------------------------
module q_table_learning_agent_core import qtla_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_item,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_wdata
);

   cfg_type cfg_ff;
   fq_type  fq_info;
   req_type fq_item;
   logic    fq_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha          <= ALPHA_RST;
         cfg_ff.discount       <= DISCOUNT_RST;
         cfg_ff.exploit_thresh <= EXPLOIT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ALPHA:    cfg_ff.alpha          <= csr_wdata;
            CSR_DISCOUNT: cfg_ff.discount       <= csr_wdata;
            CSR_EXPLOIT:  cfg_ff.exploit_thresh <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   qtla_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .fq_info  (fq_info),
      .fq_item  (fq_item),
      .fq_take  (fq_take)
   );

   qtla_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fq_info   (fq_info),
      .fq_item   (fq_item),
      .fq_take   (fq_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
